>>> design/bqsd_pkg.sv
`timescale 1ns / 1ps
// Package for the bilinear quad strain-derivative block: widths, types, constants.
// No dependencies.
package bqsd_pkg;

   localparam int NODES = 4;
   localparam int LANES = 2 * NODES;
   localparam int QBITS = 33;
   localparam int IDX_W = 3;

   typedef logic signed [15:0] nat_type;
   typedef logic signed [16:0] deriv_type;
   typedef logic signed [31:0] q16_type;
   typedef logic signed [48:0] prod_type;
   typedef logic [63:0] mag_type;

   localparam deriv_type ONE_D = 17'sd16384;
   localparam nat_type ONE_N = 16'sd16384;
   localparam nat_type NEG_ONE_N = -16'sd16384;
   localparam q16_type Q16_MAX = 32'sh7fffffff;
   localparam q16_type Q16_MIN = 32'sh80000000;

   typedef struct packed {
      q16_type det_out;
      logic singular;
   } meta_type;

   typedef struct packed {
      logic [LANES-1:0][31:0] dn;
      meta_type meta;
   } res_type;

endpackage

>>> design/bqsd_req_if.sv
`timescale 1ns / 1ps
// Input channel: one natural-coordinate point per beat.
// Depends on bqsd_pkg.
interface bqsd_req_if;
   import bqsd_pkg::*;
   logic valid;
   logic ready;
   nat_type s_coord;
   nat_type t_coord;
   modport source (output valid, s_coord, t_coord, input ready);
   modport sink (input valid, s_coord, t_coord, output ready);
endinterface

>>> design/bqsd_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: eight global derivatives, determinant and singular flag per beat.
// Depends on bqsd_pkg.
interface bqsd_rsp_if;
   import bqsd_pkg::*;
   logic valid;
   logic ready;
   q16_type dn0_dx;
   q16_type dn1_dx;
   q16_type dn2_dx;
   q16_type dn3_dx;
   q16_type dn0_dy;
   q16_type dn1_dy;
   q16_type dn2_dy;
   q16_type dn3_dy;
   q16_type jacobian_det;
   logic singular;
   modport source (output valid, dn0_dx, dn1_dx, dn2_dx, dn3_dx, dn0_dy, dn1_dy, dn2_dy,
                   dn3_dy, jacobian_det, singular, input ready);
   modport sink (input valid, dn0_dx, dn1_dx, dn2_dx, dn3_dx, dn0_dy, dn1_dy, dn2_dy,
                 dn3_dy, jacobian_det, singular, output ready);
endinterface

>>> design/bqsd_jac.sv
`timescale 1ns / 1ps
// Stages 1-3: shape derivatives, coordinate products, rounded Jacobian entries.
// Depends on bqsd_pkg.
module bqsd_jac
   import bqsd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  nat_type   s_coord,
   input  nat_type   t_coord,
   input  q16_type   node_x [NODES],
   input  q16_type   node_y [NODES],
   output logic      out_valid,
   output deriv_type ds_out [NODES],
   output deriv_type dt_out [NODES],
   output q16_type   jac_out [4]
);

   nat_type s_c, t_c;
   deriv_type s_e, t_e;
   deriv_type ds_in [NODES], dt_in [NODES];
   deriv_type ds1_ff [NODES], dt1_ff [NODES], ds2_ff [NODES], dt2_ff [NODES];
   deriv_type ds3_ff [NODES], dt3_ff [NODES];
   logic v1_ff, v2_ff, v3_ff;
   prod_type p_in [4][NODES];
   prod_type p_ff [4][NODES];
   q16_type j_in [4];
   q16_type j_ff [4];
   logic signed [50:0] sum [4];
   logic signed [50:0] rnd [4];

   always_comb begin
      s_c = s_coord;
      t_c = t_coord;
      if (s_coord > ONE_N) s_c = ONE_N;
      if (s_coord < NEG_ONE_N) s_c = NEG_ONE_N;
      if (t_coord > ONE_N) t_c = ONE_N;
      if (t_coord < NEG_ONE_N) t_c = NEG_ONE_N;
      s_e = {s_c[15], s_c};
      t_e = {t_c[15], t_c};
      ds_in[0] = t_e - ONE_D;
      ds_in[1] = ONE_D - t_e;
      ds_in[2] = t_e + ONE_D;
      ds_in[3] = -(t_e + ONE_D);
      dt_in[0] = s_e - ONE_D;
      dt_in[1] = -(s_e + ONE_D);
      dt_in[2] = s_e + ONE_D;
      dt_in[3] = ONE_D - s_e;
   end

   always_comb begin
      for (int i = 0; i < NODES; i++) begin
         p_in[0][i] = prod_type'(ds1_ff[i]) * prod_type'(node_x[i]);
         p_in[1][i] = prod_type'(dt1_ff[i]) * prod_type'(node_x[i]);
         p_in[2][i] = prod_type'(ds1_ff[i]) * prod_type'(node_y[i]);
         p_in[3][i] = prod_type'(dt1_ff[i]) * prod_type'(node_y[i]);
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sum[k] = '0;
         for (int i = 0; i < NODES; i++)
            sum[k] = sum[k] + {{2{p_ff[k][i][48]}}, p_ff[k][i]};
         rnd[k] = (sum[k] + 51'sd32768) >>> 16;
         if (rnd[k] > 51'sd2147483647)
            j_in[k] = Q16_MAX;
         else if (rnd[k] < -51'sd2147483647)
            j_in[k] = -Q16_MAX;
         else
            j_in[k] = rnd[k][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ds1_ff <= ds_in;
         dt1_ff <= dt_in;
         ds2_ff <= ds1_ff;
         dt2_ff <= dt1_ff;
         ds3_ff <= ds2_ff;
         dt3_ff <= dt2_ff;
         p_ff <= p_in;
         j_ff <= j_in;
      end
   end

   assign out_valid = v3_ff;
   assign ds_out = ds3_ff;
   assign dt_out = dt3_ff;
   assign jac_out = j_ff;

endmodule

>>> design/bqsd_det.sv
`timescale 1ns / 1ps
// Stages 4-5: determinant, numerators, magnitudes and signs for the divider lanes.
// Depends on bqsd_pkg.
module bqsd_det
   import bqsd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  deriv_type ds [NODES],
   input  deriv_type dt [NODES],
   input  q16_type   jac [4],
   output logic      out_valid,
   output mag_type   den,
   output mag_type   num [LANES],
   output logic      neg [LANES],
   output meta_type  meta
);

   logic v4_ff, v5_ff;
   logic signed [63:0] pa_ff, pb_ff;
   prod_type na_ff [LANES], nb_ff [LANES];
   prod_type na_in [LANES], nb_in [LANES];
   logic signed [64:0] det, det_abs, det_rnd;
   logic signed [49:0] nd [LANES];
   logic signed [49:0] nd_abs [LANES];
   mag_type den_ff, num_in [LANES], num_ff [LANES];
   logic neg_in [LANES], neg_ff [LANES];
   meta_type meta_in, meta_ff;

   always_comb begin
      for (int i = 0; i < NODES; i++) begin
         na_in[i] = prod_type'(ds[i]) * prod_type'(jac[3]);
         nb_in[i] = prod_type'(dt[i]) * prod_type'(jac[2]);
         na_in[NODES+i] = prod_type'(dt[i]) * prod_type'(jac[0]);
         nb_in[NODES+i] = prod_type'(ds[i]) * prod_type'(jac[1]);
      end
   end

   always_comb begin
      det = {pa_ff[63], pa_ff} - {pb_ff[63], pb_ff};
      det_abs = det[64] ? -det : det;
      det_rnd = (det + 65'sd32768) >>> 16;
      if (det_rnd > 65'sd2147483647)
         meta_in.det_out = Q16_MAX;
      else if (det_rnd < -65'sd2147483648)
         meta_in.det_out = Q16_MIN;
      else
         meta_in.det_out = det_rnd[31:0];
      meta_in.singular = (det == '0);
      for (int l = 0; l < LANES; l++) begin
         nd[l] = {na_ff[l][48], na_ff[l]} - {nb_ff[l][48], nb_ff[l]};
         nd_abs[l] = nd[l][49] ? -nd[l] : nd[l];
         num_in[l] = {nd_abs[l][47:0], 16'h0000};
         neg_in[l] = nd[l][49] ^ det[64];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= in_valid;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff <= 64'(jac[0]) * 64'(jac[3]);
         pb_ff <= 64'(jac[1]) * 64'(jac[2]);
         na_ff <= na_in;
         nb_ff <= nb_in;
         den_ff <= det_abs[63:0];
         num_ff <= num_in;
         neg_ff <= neg_in;
         meta_ff <= meta_in;
      end
   end

   assign out_valid = v5_ff;
   assign den = den_ff;
   assign num = num_ff;
   assign neg = neg_ff;
   assign meta = meta_ff;

endmodule

>>> design/bqsd_div.sv
`timescale 1ns / 1ps
// Eight-lane pipelined restoring divider, one quotient bit per stage, with
// round-half-away and saturation to Q16.16. Depends on bqsd_pkg.
module bqsd_div
   import bqsd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  mag_type  den,
   input  mag_type  num [LANES],
   input  logic     neg [LANES],
   input  meta_type meta,
   output logic     out_valid,
   output res_type  res
);

   logic v_ff [QBITS+1];
   mag_type d_ff [QBITS+1];
   meta_type m_ff [QBITS+1];
   mag_type rem_ff [QBITS+1][LANES];
   logic [QBITS-1:0] q_ff [QBITS+1][LANES];
   logic ovf_ff [QBITS+1][LANES];
   logic neg_ff [QBITS+1][LANES];
   logic ovf_in [LANES];
   logic vo_ff;
   res_type res_in, res_ff;
   logic [64:0] r2 [LANES];
   logic [QBITS:0] qr [LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++)
         ovf_in[l] = (num[l] >> QBITS) >= den;
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else if (en) v_ff[0] <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff[0] <= den;
         m_ff[0] <= meta;
         rem_ff[0] <= num;
         neg_ff[0] <= neg;
         ovf_ff[0] <= ovf_in;
         for (int l = 0; l < LANES; l++) q_ff[0][l] <= '0;
      end
   end

   for (genvar k = 1; k <= QBITS; k++) begin : g_step
      localparam int B = QBITS - k;
      mag_type rem_in [LANES];
      logic [QBITS-1:0] q_in [LANES];

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            rem_in[l] = rem_ff[k-1][l];
            q_in[l] = q_ff[k-1][l];
            if ((rem_ff[k-1][l] >> B) >= d_ff[k-1]) begin
               rem_in[l] = rem_ff[k-1][l] - (d_ff[k-1] << B);
               q_in[l][B] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) v_ff[k] <= 1'b0;
         else if (en) v_ff[k] <= v_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[k] <= d_ff[k-1];
            m_ff[k] <= m_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
            rem_ff[k] <= rem_in;
            q_ff[k] <= q_in;
         end
      end
   end

   always_comb begin
      res_in.meta = m_ff[QBITS];
      for (int l = 0; l < LANES; l++) begin
         r2[l] = {rem_ff[QBITS][l], 1'b0};
         qr[l] = {1'b0, q_ff[QBITS][l]} + {{QBITS{1'b0}}, (r2[l] >= {1'b0, d_ff[QBITS]})};
         if (m_ff[QBITS].singular)
            res_in.dn[l] = '0;
         else if (neg_ff[QBITS][l]) begin
            if (ovf_ff[QBITS][l] || qr[l] > (QBITS+1)'(34'h080000000))
               res_in.dn[l] = Q16_MIN;
            else
               res_in.dn[l] = -qr[l][31:0];
         end else begin
            if (ovf_ff[QBITS][l] || qr[l] > (QBITS+1)'(34'h07fffffff))
               res_in.dn[l] = Q16_MAX;
            else
               res_in.dn[l] = qr[l][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else if (en) vo_ff <= v_ff[QBITS];
   end

   always_ff @(posedge clock) begin
      if (en) res_ff <= res_in;
   end

   assign out_valid = vo_ff;
   assign res = res_ff;

endmodule

>>> design/bilinear_quad_strain_derivatives_top.sv
`timescale 1ns / 1ps
// Strain-derivative unit for a four-node bilinear quadrilateral: top level.
// Depends on bqsd_pkg, bqsd_req_if, bqsd_rsp_if, bqsd_jac, bqsd_det, bqsd_div.
//
// One (s,t) point is taken per clock while the skid stage is empty; the divider
// resolves one quotient bit per stage for all eight derivatives. Node coordinates
// are to be written through the csr port only while no point is in flight; the user
// must ensure this, as the block does not enforce it. An output register and a
// one-beat skid stage keep the input open while one result waits on rsp_bus.ready.
module bilinear_quad_strain_derivatives_top
   import bqsd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   bqsd_req_if.sink          req_bus,
   bqsd_rsp_if.source        rsp_bus,
   input  logic              csr_write,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [31:0]       csr_data
);

   q16_type node_x_ff [NODES], node_y_ff [NODES];
   logic en;
   logic jv, dv, pv;
   deriv_type ds [NODES], dt [NODES];
   q16_type jac [4];
   mag_type den, num [LANES];
   logic neg [LANES];
   meta_type meta;
   res_type p_res, out_ff, skid_ff;
   logic out_v_ff, skid_v_ff;
   logic take_skid, take_pipe, fill_skid;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NODES; i++) begin
            node_x_ff[i] <= '0;
            node_y_ff[i] <= '0;
         end
      end else if (csr_write) begin
         if (csr_index[IDX_W-1])
            node_y_ff[csr_index[IDX_W-2:0]] <= csr_data;
         else
            node_x_ff[csr_index[IDX_W-2:0]] <= csr_data;
      end
   end

   assign en = !skid_v_ff;
   assign req_bus.ready = en;

   bqsd_jac u_jac (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_bus.valid), .s_coord(req_bus.s_coord), .t_coord(req_bus.t_coord),
      .node_x(node_x_ff), .node_y(node_y_ff),
      .out_valid(jv), .ds_out(ds), .dt_out(dt), .jac_out(jac)
   );

   bqsd_det u_det (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(jv), .ds(ds), .dt(dt), .jac(jac),
      .out_valid(dv), .den(den), .num(num), .neg(neg), .meta(meta)
   );

   bqsd_div u_div (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(dv), .den(den), .num(num), .neg(neg), .meta(meta),
      .out_valid(pv), .res(p_res)
   );

   always_comb begin
      take_skid = skid_v_ff && rsp_bus.ready;
      fill_skid = !skid_v_ff && pv && out_v_ff && !rsp_bus.ready;
      take_pipe = !skid_v_ff && pv && !(out_v_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (take_skid) skid_v_ff <= 1'b0;
         else if (fill_skid) skid_v_ff <= 1'b1;
         if (take_skid || take_pipe) out_v_ff <= 1'b1;
         else if (rsp_bus.ready) out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_skid) out_ff <= skid_ff;
      else if (take_pipe) out_ff <= p_res;
      if (fill_skid) skid_ff <= p_res;
   end

   assign rsp_bus.valid = out_v_ff;
   assign rsp_bus.dn0_dx = out_ff.dn[0];
   assign rsp_bus.dn1_dx = out_ff.dn[1];
   assign rsp_bus.dn2_dx = out_ff.dn[2];
   assign rsp_bus.dn3_dx = out_ff.dn[3];
   assign rsp_bus.dn0_dy = out_ff.dn[4];
   assign rsp_bus.dn1_dy = out_ff.dn[5];
   assign rsp_bus.dn2_dy = out_ff.dn[6];
   assign rsp_bus.dn3_dy = out_ff.dn[7];
   assign rsp_bus.jacobian_det = out_ff.meta.det_out;
   assign rsp_bus.singular = out_ff.meta.singular;

endmodule

>>> design/bqsd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the strain-derivative top level, and the bind that attaches them.
// Depends on bqsd_pkg and bilinear_quad_strain_derivatives_top.
module bqsd_checker
   import bqsd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input q16_type dn0_dx,
   input q16_type dn1_dx,
   input q16_type dn2_dx,
   input q16_type dn3_dx,
   input q16_type dn0_dy,
   input q16_type dn1_dy,
   input q16_type dn2_dy,
   input q16_type dn3_dy,
   input q16_type jacobian_det,
   input logic    singular
);

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && singular |-> dn0_dx == 0 && dn1_dx == 0 && dn2_dx == 0 && dn3_dx == 0 &&
      dn0_dy == 0 && dn1_dy == 0 && dn2_dy == 0 && dn3_dy == 0)
      else $error("singular beat with nonzero derivative");

   a_sing_det: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && singular |-> jacobian_det == 0)
      else $error("singular beat with nonzero determinant");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat straight after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(dn0_dx) && $stable(dn3_dy) &&
      $stable(jacobian_det) && $stable(singular))
      else $error("stalled result beat changed");

endmodule

bind bilinear_quad_strain_derivatives_top bqsd_checker u_bqsd_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready),
   .dn0_dx(rsp_bus.dn0_dx), .dn1_dx(rsp_bus.dn1_dx),
   .dn2_dx(rsp_bus.dn2_dx), .dn3_dx(rsp_bus.dn3_dx),
   .dn0_dy(rsp_bus.dn0_dy), .dn1_dy(rsp_bus.dn1_dy),
   .dn2_dy(rsp_bus.dn2_dy), .dn3_dy(rsp_bus.dn3_dy),
   .jacobian_det(rsp_bus.jacobian_det), .singular(rsp_bus.singular)
);
